// File: hw/rtl/ecol_pkg.sv
// Shared types, constants and arithmetic helpers for the pair-collision axis pipeline.
`default_nettype none
package ecol_pkg;

	localparam int WORD_BITS = 32;
	localparam int EXT_BITS  = 31;
	localparam int QUOT_BITS = 34;
	localparam int DIV_STEPS = QUOT_BITS / 2;
	localparam int STAGES    = DIV_STEPS + 4;

	localparam logic signed [35:0] SAT_HI = 36'sh07FFFFFFF;
	localparam logic signed [35:0] SAT_LO = -36'sh080000000;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] pos_a;
		logic signed [WORD_BITS-1:0] pos_b;
		logic signed [WORD_BITS-1:0] vel_a;
		logic signed [WORD_BITS-1:0] vel_b;
		logic [EXT_BITS-1:0]         extent_a;
		logic [EXT_BITS-1:0]         extent_b;
		logic [EXT_BITS-1:0]         mass_a;
		logic [EXT_BITS-1:0]         mass_b;
	} req_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] new_pos_a;
		logic signed [WORD_BITS-1:0] new_pos_b;
		logic signed [WORD_BITS-1:0] new_vel_a;
		logic signed [WORD_BITS-1:0] new_vel_b;
		logic                        hit;
		logic                        clipped;
		logic                        mass_fault;
	} rsp_t;

	// sideband that rides along the divider
	typedef struct packed {
		logic                        hit;
		logic                        mfault;
		logic                        pclip;
		logic                        neg_a;
		logic                        neg_b;
		logic                        ovf_a;
		logic                        ovf_b;
		logic [WORD_BITS-1:0]        msum;
		logic signed [WORD_BITS-1:0] vel_a;
		logic signed [WORD_BITS-1:0] vel_b;
		logic signed [WORD_BITS-1:0] pos_a;
		logic signed [WORD_BITS-1:0] pos_b;
	} side_t;

	// partial remainder and dividend/quotient shift word
	typedef struct packed {
		logic [WORD_BITS-1:0] rem;
		logic [QUOT_BITS-1:0] sh;
	} lane_t;

	// two restoring-division steps; rem stays below m
	function automatic lane_t div_step(lane_t l, logic [WORD_BITS-1:0] m);
		lane_t r;
		logic [WORD_BITS:0] t;
		r = l;
		for (int k = 0; k < 2; k++) begin
			t = {r.rem, r.sh[QUOT_BITS-1]};
			if (t >= {1'b0, m}) begin
				r.rem = WORD_BITS'(t - {1'b0, m});
				r.sh  = {r.sh[QUOT_BITS-2:0], 1'b1};
			end else begin
				r.rem = t[WORD_BITS-1:0];
				r.sh  = {r.sh[QUOT_BITS-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	// {clip, value}
	function automatic logic [WORD_BITS:0] sat_word(logic signed [35:0] v);
		logic [WORD_BITS:0] r;
		if (v > SAT_HI)
			r = {1'b1, SAT_HI[WORD_BITS-1:0]};
		else if (v < SAT_LO)
			r = {1'b1, SAT_LO[WORD_BITS-1:0]};
		else
			r = {1'b0, v[WORD_BITS-1:0]};
		return r;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/ecol_div_stage.sv
// One registered stage of the pipelined divider: two quotient bits for each lane.
`default_nettype none
module ecol_div_stage import ecol_pkg::*; (
	input  wire logic  clk,
	input  wire logic  adv,
	input  wire side_t side_in,
	input  wire lane_t lane_a_in,
	input  wire lane_t lane_b_in,
	output side_t      side_out,
	output lane_t      lane_a_out,
	output lane_t      lane_b_out
);

	always_ff @(posedge clk) begin
		if (adv) begin
			side_out   <= side_in;
			lane_a_out <= div_step(lane_a_in, side_in.msum);
			lane_b_out <= div_step(lane_b_in, side_in.msum);
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/elastic_pair_collision_axis.sv
// Top level: one-axis elastic collision and separation of a body pair, fully pipelined.
//
//  channel  dir  handshake             payload
//  req      in   req_valid/req_stall   req_data (req_t)
//  rsp      out  rsp_valid/rsp_stall   rsp_data (rsp_t)
//
// The pipeline stages (STAGES) are operand prep, multiply and separation, divider
// setup, 17 divider stages at two quotient bits each, then rounding/saturation.
// One transfer per cycle sustained while rsp_stall is low. Each stage holds its item and only advances
// when the next stage is empty or advancing, so bubbles collapse under stall.
// Reset clears the valid bits only; payload registers are not reset.
`default_nettype none
module elastic_pair_collision_axis import ecol_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req_data,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp_data
);

	logic [STAGES-1:0] vld_q;
	logic [STAGES-1:0] adv;

	// stage i moves when it is empty or stage i+1 moves
	always_comb begin
		adv[STAGES-1] = !vld_q[STAGES-1] || !rsp_stall;
		for (int i = STAGES-2; i >= 0; i--)
			adv[i] = !vld_q[i] || adv[i+1];
	end

	assign req_stall = !adv[0];
	assign rsp_valid = vld_q[STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0])
				vld_q[0] <= req_valid;
			for (int i = 1; i < STAGES; i++)
				if (adv[i])
					vld_q[i] <= vld_q[i-1];
		end
	end

	// ---- stage 1: differences and sums
	logic signed [WORD_BITS-1:0] pa_s1, pb_s1, va_s1, vb_s1;
	logic signed [WORD_BITS:0]   d_s1, dv_s1;
	logic [WORD_BITS-1:0]        len_s1, msum_s1;
	logic [EXT_BITS-1:0]         ma_s1, mb_s1;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			pa_s1   <= req_data.pos_a;
			pb_s1   <= req_data.pos_b;
			va_s1   <= req_data.vel_a;
			vb_s1   <= req_data.vel_b;
			d_s1    <= (WORD_BITS+1)'(req_data.pos_b) - (WORD_BITS+1)'(req_data.pos_a);
			dv_s1   <= (WORD_BITS+1)'(req_data.vel_b) - (WORD_BITS+1)'(req_data.vel_a);
			len_s1  <= WORD_BITS'(req_data.extent_a) + WORD_BITS'(req_data.extent_b);
			msum_s1 <= WORD_BITS'(req_data.mass_a) + WORD_BITS'(req_data.mass_b);
			ma_s1   <= req_data.mass_a;
			mb_s1   <= req_data.mass_b;
		end
	end

	// ---- stage 2: overlap test, separation, the two products
	logic [WORD_BITS:0]        ad, dmag, gap;
	logic [WORD_BITS-2:0]      half;
	logic                      hit;
	logic signed [35:0]        npa, npb;
	logic [WORD_BITS:0]        spa, spb;
	logic [2*WORD_BITS:0]      prod_a, prod_b;

	always_comb begin
		ad   = d_s1[WORD_BITS] ? (WORD_BITS+1)'(-d_s1) : (WORD_BITS+1)'(d_s1);
		dmag = dv_s1[WORD_BITS] ? (WORD_BITS+1)'(-dv_s1) : (WORD_BITS+1)'(dv_s1);
		hit  = ad < {1'b0, len_s1};
		gap  = {1'b0, len_s1} - ad;
		half = gap[WORD_BITS-1:1];
		// positive distance pushes a down, otherwise a goes up
		if (!d_s1[WORD_BITS] && d_s1 != '0) begin
			npa = 36'(pa_s1) - $signed({5'b0, half});
			npb = 36'(pb_s1) + $signed({5'b0, half});
		end else begin
			npa = 36'(pa_s1) + $signed({5'b0, half});
			npb = 36'(pb_s1) - $signed({5'b0, half});
		end
		spa    = sat_word(npa);
		spb    = sat_word(npb);
		prod_a = {mb_s1, 1'b0} * dmag;
		prod_b = {ma_s1, 1'b0} * dmag;
	end

	logic                        hit_s2, pclip_s2, nega_s2, negb_s2;
	logic signed [WORD_BITS-1:0] pa_s2, pb_s2, va_s2, vb_s2;
	logic [WORD_BITS-1:0]        msum_s2;
	logic [2*WORD_BITS-1:0]      pra_s2, prb_s2;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			hit_s2   <= hit;
			pclip_s2 <= hit && (spa[WORD_BITS] || spb[WORD_BITS]);
			pa_s2    <= hit ? $signed(spa[WORD_BITS-1:0]) : pa_s1;
			pb_s2    <= hit ? $signed(spb[WORD_BITS-1:0]) : pb_s1;
			va_s2    <= va_s1;
			vb_s2    <= vb_s1;
			msum_s2  <= msum_s1;
			nega_s2  <= dv_s1[WORD_BITS];
			negb_s2  <= !dv_s1[WORD_BITS] && dv_s1 != '0;
			pra_s2   <= prod_a[2*WORD_BITS-1:0];
			prb_s2   <= prod_b[2*WORD_BITS-1:0];
		end
	end

	// ---- stage 3: divider setup; a quotient of 2^34 or more always saturates
	logic ovfa, ovfb;
	side_t side_s3;
	lane_t lane_a_s3, lane_b_s3;

	assign ovfa = {2'b0, pra_s2[2*WORD_BITS-1:QUOT_BITS]} >= msum_s2;
	assign ovfb = {2'b0, prb_s2[2*WORD_BITS-1:QUOT_BITS]} >= msum_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			side_s3.hit    <= hit_s2;
			side_s3.mfault <= msum_s2 == '0;
			side_s3.pclip  <= pclip_s2;
			side_s3.neg_a  <= nega_s2;
			side_s3.neg_b  <= negb_s2;
			side_s3.ovf_a  <= ovfa;
			side_s3.ovf_b  <= ovfb;
			side_s3.msum   <= msum_s2;
			side_s3.vel_a  <= va_s2;
			side_s3.vel_b  <= vb_s2;
			side_s3.pos_a  <= pa_s2;
			side_s3.pos_b  <= pb_s2;
			lane_a_s3.rem  <= ovfa ? '0 : {2'b0, pra_s2[2*WORD_BITS-1:QUOT_BITS]};
			lane_a_s3.sh   <= pra_s2[QUOT_BITS-1:0];
			lane_b_s3.rem  <= ovfb ? '0 : {2'b0, prb_s2[2*WORD_BITS-1:QUOT_BITS]};
			lane_b_s3.sh   <= prb_s2[QUOT_BITS-1:0];
		end
	end

	// ---- divider stages
	side_t side_d [DIV_STEPS+1];
	lane_t lane_a_d [DIV_STEPS+1];
	lane_t lane_b_d [DIV_STEPS+1];

	assign side_d[0]   = side_s3;
	assign lane_a_d[0] = lane_a_s3;
	assign lane_b_d[0] = lane_b_s3;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		ecol_div_stage u_stage (
			.clk        (clk),
			.adv        (adv[3+k]),
			.side_in    (side_d[k]),
			.lane_a_in  (lane_a_d[k]),
			.lane_b_in  (lane_b_d[k]),
			.side_out   (side_d[k+1]),
			.lane_a_out (lane_a_d[k+1]),
			.lane_b_out (lane_b_d[k+1])
		);
	end

	// ---- last stage: rounding to nearest (ties up), add, saturate
	side_t side_f;
	lane_t la, lb;
	logic [QUOT_BITS:0]   qa, qb;
	logic                 upa, upb;
	logic signed [35:0]   nva, nvb;
	logic [WORD_BITS:0]   sva, svb;
	rsp_t                 res;

	always_comb begin
		side_f = side_d[DIV_STEPS];
		la     = lane_a_d[DIV_STEPS];
		lb     = lane_b_d[DIV_STEPS];
		upa = side_f.neg_a ? ({la.rem, 1'b0} > {1'b0, side_f.msum})
		                   : ({la.rem, 1'b0} >= {1'b0, side_f.msum});
		upb = side_f.neg_b ? ({lb.rem, 1'b0} > {1'b0, side_f.msum})
		                   : ({lb.rem, 1'b0} >= {1'b0, side_f.msum});
		qa = side_f.ovf_a ? {1'b1, {QUOT_BITS{1'b0}}} : {1'b0, la.sh} + (QUOT_BITS+1)'(upa);
		qb = side_f.ovf_b ? {1'b1, {QUOT_BITS{1'b0}}} : {1'b0, lb.sh} + (QUOT_BITS+1)'(upb);
		nva = side_f.neg_a ? 36'(side_f.vel_a) - $signed({1'b0, qa})
		                   : 36'(side_f.vel_a) + $signed({1'b0, qa});
		nvb = side_f.neg_b ? 36'(side_f.vel_b) - $signed({1'b0, qb})
		                   : 36'(side_f.vel_b) + $signed({1'b0, qb});
		sva = sat_word(nva);
		svb = sat_word(nvb);

		res.new_pos_a  = side_f.pos_a;
		res.new_pos_b  = side_f.pos_b;
		res.hit        = side_f.hit;
		res.mass_fault = side_f.hit && side_f.mfault;
		if (side_f.hit && !side_f.mfault) begin
			res.new_vel_a = $signed(sva[WORD_BITS-1:0]);
			res.new_vel_b = $signed(svb[WORD_BITS-1:0]);
			res.clipped   = side_f.pclip || sva[WORD_BITS] || svb[WORD_BITS];
		end else begin
			res.new_vel_a = side_f.vel_a;
			res.new_vel_b = side_f.vel_b;
			res.clipped   = side_f.pclip;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[STAGES-1])
			rsp_data <= res;
	end

`ifndef ASSERT_OFF
	// the input only stalls when every stage is full and the output is held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (rsp_valid && rsp_stall && (&vld_q)))
		else $error("input stalled with room in the pipeline");

	a_fault_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.mass_fault |-> rsp_data.hit)
		else $error("mass fault without overlap");

	a_clip_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.clipped |-> rsp_data.hit)
		else $error("clip flagged on a pass-through transfer");

	a_no_lose: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("held result changed or dropped");
`endif

endmodule
`default_nettype wire

// File: test/tb.sv
// Testbench for the one-axis elastic pair collision pipeline.
`default_nettype none
module tb;
	import ecol_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Expected collision results and their comparison against the block's output.
	class collision_board;
		rsp_t pending[$];
		int   errors;

		// rounded 2*m*d/msum, ties toward +inf
		function automatic longint impulse(longint m, longint d, longint msum);
			logic [127:0] p, q, r;
			logic neg;
			longint mag;
			neg = d < 0;
			mag = neg ? -d : d;
			p = 128'(2 * m) * 128'(mag);
			q = p / 128'(msum);
			r = p % 128'(msum);
			if (!neg) begin
				if (2 * r >= 128'(msum)) q++;
				return longint'(q);
			end
			if (2 * r > 128'(msum)) q++;
			return -longint'(q);
		endfunction

		function automatic longint clamp(longint v, ref bit clip);
			if (v > 64'sd2147483647) begin
				clip = 1;
				return 64'sd2147483647;
			end
			if (v < -64'sd2147483648) begin
				clip = 1;
				return -64'sd2147483648;
			end
			return v;
		endfunction

		function void note_request(req_t q);
			rsp_t e;
			longint pa, pb, va, vb, len, d, ad, msum, h, nva, nvb;
			bit clip;
			pa = q.pos_a;
			pb = q.pos_b;
			va = q.vel_a;
			vb = q.vel_b;
			len = longint'(q.extent_a) + longint'(q.extent_b);
			msum = longint'(q.mass_a) + longint'(q.mass_b);
			d = pb - pa;
			ad = d < 0 ? -d : d;
			clip = 0;
			e = '0;
			if (ad >= len) begin
				e.new_pos_a = q.pos_a;
				e.new_pos_b = q.pos_b;
				e.new_vel_a = q.vel_a;
				e.new_vel_b = q.vel_b;
			end else begin
				e.hit = 1;
				if (msum == 0)
					e.mass_fault = 1;
				else begin
					nva = va + impulse(q.mass_b, vb - va, msum);
					nvb = vb + impulse(q.mass_a, va - vb, msum);
					va = nva;
					vb = nvb;
				end
				va = clamp(va, clip);
				vb = clamp(vb, clip);
				if (d > 0) begin
					h = (len - d) / 2;
					pa -= h;
					pb += h;
				end else begin
					h = (len + d) / 2;
					pa += h;
					pb -= h;
				end
				pa = clamp(pa, clip);
				pb = clamp(pb, clip);
				e.new_pos_a = pa[31:0];
				e.new_pos_b = pb[31:0];
				e.new_vel_a = va[31:0];
				e.new_vel_b = vb[31:0];
				e.clipped = clip;
			end
			pending = {pending, e};
		endfunction

		task report(string what, logic [131:0] want, logic [131:0] got);
			errors++;
			$display("MISMATCH %s: expected %0h got %0h", what, want, got);
		endtask

		task check_response(rsp_t r);
			rsp_t e;
			if (pending.size() == 0) begin
				report("unexpected response", 0, r);
				return;
			end
			e = pending.pop_front();
			if (r.new_pos_a !== e.new_pos_a) report("new_pos_a", e.new_pos_a, r.new_pos_a);
			if (r.new_pos_b !== e.new_pos_b) report("new_pos_b", e.new_pos_b, r.new_pos_b);
			if (r.new_vel_a !== e.new_vel_a) report("new_vel_a", e.new_vel_a, r.new_vel_a);
			if (r.new_vel_b !== e.new_vel_b) report("new_vel_b", e.new_vel_b, r.new_vel_b);
			if (r.hit !== e.hit) report("hit", e.hit, r.hit);
			if (r.clipped !== e.clipped) report("clipped", e.clipped, r.clipped);
			if (r.mass_fault !== e.mass_fault) report("mass_fault", e.mass_fault, r.mass_fault);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic req_valid = 0;
	logic req_stall;
	req_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 1;
	rsp_t rsp_data;

	collision_board board = new();

	// idle odds in percent; hold-off forces a long receiver stall
	int send_idle = 25, recv_idle = 66;
	bit hold_off = 0;
	int quiet = 0;
	int accepted = 0;

	always #4 clk = ~clk;

	elastic_pair_collision_axis DUT (.*);

	// Sample both handshakes at the rising edge.
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall) begin
			board.note_request(req_data);
			accepted++;
		end
		if (arst_n && rsp_valid && !rsp_stall)
			board.check_response(rsp_data);
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet = 0;
		else
			quiet++;
		if (quiet > 5000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver stall pattern, changing at the falling edge.
	always @(negedge clk)
		rsp_stall <= hold_off || ($urandom_range(99) < recv_idle);

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom_range(32'h40000) - 32'h20000;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [30:0] rand_size();
		case ($urandom_range(5))
			0: return 31'h7FFFFFFF;
			1: return 31'h0;
			2: return 31'($urandom_range(32'h40000));
			default: return 31'($urandom());
		endcase
	endfunction

	// Mostly overlapping pairs near each other, plus fully random noise.
	function automatic req_t random_pair();
		req_t q;
		q.pos_a = rand_word();
		q.vel_a = rand_word();
		q.vel_b = rand_word();
		q.extent_a = rand_size();
		q.extent_b = rand_size();
		q.mass_a = rand_size();
		q.mass_b = rand_size();
		if ($urandom_range(3) != 0)
			q.pos_b = q.pos_a + ($urandom_range(32'h30000) - 32'h18000);
		else
			q.pos_b = rand_word();
		return q;
	endfunction

	// One transfer: present, optionally idle first, wait for acceptance.
	task automatic send_pair(req_t q);
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 0;
			@(negedge clk);
		end
		req_valid <= 1;
		req_data <= q;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_directed();
		req_t q;
		// no overlap: pass-through
		q = '{32'h10000, 32'h50000, 32'h1234, -32'sh5678, 31'h10000, 31'h10000,
			31'h10000, 31'h20000};
		send_pair(q);
		// zero distance
		q.pos_b = q.pos_a;
		send_pair(q);
		// overlap, d > 0
		q.pos_b = q.pos_a + 32'h8000;
		send_pair(q);
		// zero mass sum with overlap
		q.mass_a = 0;
		q.mass_b = 0;
		send_pair(q);
		// one zero mass
		q.mass_b = 31'h7FFFFFFF;
		send_pair(q);
		// saturating positions and velocities
		q = '{32'h7FFFFFFF, 32'h7FFFFFF0, 32'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF,
			31'h7FFFFFFF, 31'h7FFFFFFF, 31'h1};
		send_pair(q);
		q = '{32'h80000000, 32'h80000010, 32'h80000000, 32'h7FFFFFFF, 31'h7FFFFFFF,
			31'h7FFFFFFF, 31'h1, 31'h7FFFFFFF};
		send_pair(q);
		q = '{32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h0, 31'h7FFFFFFF,
			31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF};
		send_pair(q);
		q = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h1, 31'h7FFFFFFF,
			31'h7FFFFFFF, 31'h3, 31'h3};
		send_pair(q);
		// extents exactly equal to distance
		q = '{32'h0, 32'h20000, 32'h1, 32'h2, 31'h10000, 31'h10000, 31'h1, 31'h1};
		send_pair(q);
		// equal masses, then rounding ties with unequal masses
		q = '{32'h0, 32'h1, 32'h1, 32'h0, 31'h2, 31'h2, 31'h1, 31'h1};
		send_pair(q);
		q = '{32'h0, 32'hFFFFFFFF, 32'h0, 32'h1, 31'h2, 31'h1, 31'h3, 31'h1};
		send_pair(q);
		// all zero, then all ones
		send_pair('0);
		q = '1;
		send_pair(q);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		send_directed();
		for (int i = 0; i < 330; i++) send_pair(random_pair());

		send_idle = 66;
		recv_idle = 25;
		for (int i = 0; i < 330; i++) send_pair(random_pair());

		// long hold-off on the response side fills the pipeline
		send_idle = 0;
		recv_idle = 0;
		fork
			begin
				hold_off = 1;
				repeat (200) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 60; i++) send_pair(random_pair());
		join
		for (int i = 0; i < 280; i++) send_pair(random_pair());
		req_valid <= 0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (board.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire
